>>> sv/stc_pkg.sv
`timescale 1ns / 1ps

package stc_pkg;

  // Sub-second ticks; each tick event in run mode advances one of these.
  localparam int TicksPerSecond = 2;
  localparam int TickW = (TicksPerSecond > 1) ? $clog2(TicksPerSecond) : 1;
  localparam logic [TickW-1:0] TickLast = TickW'(TicksPerSecond - 1);

  localparam logic [5:0] SecLast  = 6'd59;
  localparam logic [5:0] MinLast  = 6'd59;
  localparam logic [4:0] HourLast = 5'd23;

  typedef enum logic [1:0] {
    OpTick   = 2'd0,
    OpToggle = 2'd1,
    OpPoll   = 2'd2
  } op_e;

  typedef struct packed {
    logic hour_up;
    logic hour_down;
    logic minute_up;
    logic minute_down;
  } btn_t;

  // Time of day held as a mixed-radix count (hours:minutes:seconds:ticks), plus LED and set mode.
  typedef struct packed {
    logic [4:0]       hr;
    logic [5:0]       mn;
    logic [5:0]       sec;
    logic [TickW-1:0] sub;
    logic             led;
    logic             set_mode;
  } time_t;

  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] minute_tens;
    logic [3:0] minute_units;
  } digits_t;

  function automatic logic [4:0] hour_inc(logic [4:0] h);
    return (h >= HourLast) ? 5'd0 : h + 5'd1;
  endfunction

  function automatic logic [4:0] hour_dec(logic [4:0] h);
    return (h == 5'd0) ? HourLast : h - 5'd1;
  endfunction

endpackage

>>> sv/settable_time_of_day_counter.sv
`timescale 1ns / 1ps
// The result of an accepted input transaction is held in the output register.
// Throughput: one event per cycle while results are taken; the time-of-day update is a single pass of
//   carry logic on the hour/minute/second/tick counters, so events go back to back.
// Reset (rst_ni low, asynchronous): time 00:00:00, run mode, LED low, output empty.
module settable_time_of_day_counter (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] hour_up, [1] hour_down, [2] minute_up, [3] minute_down, [7:4] zero
  input  logic [7:0]  s_axis_tdata,
  // [1:0] operation (0 tick, 1 toggle set mode, 2 poll buttons)
  input  logic [1:0]  s_axis_tuser,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] hours_now, [10:5] minutes_now, [16:11] seconds_now, [18:17] hour_tens,
  // [22:19] hour_units, [25:23] minute_tens, [29:26] minute_units,
  // [30] second_led, [31] setting_mode
  output logic [31:0] m_axis_tdata
);

  logic             accept;
  stc_pkg::op_e     op;
  stc_pkg::btn_t    btn;
  stc_pkg::time_t   time_d;
  stc_pkg::digits_t digits;

  logic        out_valid_q;
  logic        out_valid_d;
  logic [31:0] out_data_q;

  // The output register frees up in the same cycle its result is taken.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign op  = stc_pkg::op_e'(s_axis_tuser);
  assign btn = '{hour_up:     s_axis_tdata[0],
                 hour_down:   s_axis_tdata[1],
                 minute_up:   s_axis_tdata[2],
                 minute_down: s_axis_tdata[3]};

  // Counter state is updated on each accepted transaction; time_d is its next value.
  stc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .op_i     (op),
    .btn_i    (btn),
    .time_d_o (time_d)
  );

  // Decimal digits for the display, from the updated time.
  stc_format u_format (
    .hr_i     (time_d.hr),
    .mn_i     (time_d.mn),
    .digits_o (digits)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload; seconds are whole seconds, the sub-second ticks stay internal.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {time_d.set_mode, time_d.led,
                     digits.minute_units, digits.minute_tens,
                     digits.hour_units, digits.hour_tens,
                     time_d.sec, time_d.mn, time_d.hr};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> sv/stc_core.sv
`timescale 1ns / 1ps

module stc_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  stc_pkg::op_e  op_i,
  input  stc_pkg::btn_t btn_i,
  output stc_pkg::time_t time_d_o
);

  stc_pkg::time_t time_q;
  stc_pkg::time_t time_d;

  always_comb begin
    time_d = time_q;
    case (op_i)
      stc_pkg::OpTick: begin
        if (!time_q.set_mode) begin
          time_d.led = ~time_q.led;
          if (time_q.sub >= stc_pkg::TickLast) begin
            time_d.sub = '0;
            if (time_q.sec >= stc_pkg::SecLast) begin
              time_d.sec = 6'd0;
              if (time_q.mn >= stc_pkg::MinLast) begin
                time_d.mn = 6'd0;
                time_d.hr = stc_pkg::hour_inc(time_q.hr);
              end else begin
                time_d.mn = time_q.mn + 6'd1;
              end
            end else begin
              time_d.sec = time_q.sec + 6'd1;
            end
          end else begin
            time_d.sub = time_q.sub + stc_pkg::TickW'(1);
          end
        end
      end
      stc_pkg::OpToggle: begin
        time_d.set_mode = ~time_q.set_mode;
      end
      stc_pkg::OpPoll: begin
        if (time_q.set_mode) begin
          // buttons apply in a fixed order: hour up, hour down, minute up, minute down
          if (btn_i.hour_up)   time_d.hr = stc_pkg::hour_inc(time_d.hr);
          if (btn_i.hour_down) time_d.hr = stc_pkg::hour_dec(time_d.hr);
          if (btn_i.minute_up) begin
            if (time_d.mn >= stc_pkg::MinLast) begin
              time_d.mn = 6'd0;
              time_d.hr = stc_pkg::hour_inc(time_d.hr);
            end else begin
              time_d.mn = time_d.mn + 6'd1;
            end
          end
          if (btn_i.minute_down) begin
            if (time_d.mn == 6'd0) begin
              time_d.mn = stc_pkg::MinLast;
              time_d.hr = stc_pkg::hour_dec(time_d.hr);
            end else begin
              time_d.mn = time_d.mn - 6'd1;
            end
          end
        end
      end
      default: begin
        time_d = time_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
    end else if (accept_i) begin
      time_q <= time_d;
    end
  end

  assign time_d_o = time_d;

  // Counter digits stay within their radix.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    time_q.hr <= stc_pkg::HourLast && time_q.mn <= stc_pkg::MinLast &&
    time_q.sec <= stc_pkg::SecLast && time_q.sub <= stc_pkg::TickLast)
    else $error("time of day counter out of range");

  // A tick while setting changes nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && op_i == stc_pkg::OpTick && time_q.set_mode |=> $stable(time_q))
    else $error("tick altered time in set mode");

  // A poll while running changes nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && op_i == stc_pkg::OpPoll && !time_q.set_mode |=> $stable(time_q))
    else $error("poll altered time in run mode");

  // The LED toggles exactly on a running tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && op_i == stc_pkg::OpTick && !time_q.set_mode |=>
    time_q.led != $past(time_q.led))
    else $error("LED did not toggle on tick");

endmodule

>>> sv/stc_format.sv
`timescale 1ns / 1ps

module stc_format (
  input  logic [4:0]      hr_i,
  input  logic [5:0]      mn_i,
  output stc_pkg::digits_t digits_o
);

  logic [2:0] mn_tens;

  always_comb begin
    if (hr_i >= 5'd20) begin
      digits_o.hour_tens  = 2'd2;
      digits_o.hour_units = 4'(hr_i - 5'd20);
    end else if (hr_i >= 5'd10) begin
      digits_o.hour_tens  = 2'd1;
      digits_o.hour_units = 4'(hr_i - 5'd10);
    end else begin
      digits_o.hour_tens  = 2'd0;
      digits_o.hour_units = 4'(hr_i);
    end

    if (mn_i >= 6'd50)      mn_tens = 3'd5;
    else if (mn_i >= 6'd40) mn_tens = 3'd4;
    else if (mn_i >= 6'd30) mn_tens = 3'd3;
    else if (mn_i >= 6'd20) mn_tens = 3'd2;
    else if (mn_i >= 6'd10) mn_tens = 3'd1;
    else                    mn_tens = 3'd0;

    digits_o.minute_tens  = mn_tens;
    digits_o.minute_units = 4'(mn_i - 6'(mn_tens) * 6'd10);
  end

endmodule

>>> tb/sv/tod_display_checker.sv
`timescale 1ns / 1ps

module tod_display_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int unsigned DayTicks    = 86400 * stc_pkg::TicksPerSecond;
  localparam int unsigned HourTicks   = 3600 * stc_pkg::TicksPerSecond;
  localparam int unsigned MinuteTicks = 60 * stc_pkg::TicksPerSecond;

  typedef struct {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [1:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] minute_tens;
    logic [3:0] minute_units;
    logic       led;
    logic       setting;
  } tod_display_t;

  // Model state: ticks since midnight, set mode, seconds LED.
  int unsigned  day_ticks_now;
  logic         setting_now;
  logic         led_now;
  tod_display_t expected_displays[$];
  int           mismatches = 0;
  int           result_index = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic int unsigned add_wrapped(int unsigned count, int unsigned step);
    int unsigned sum;
    sum = count + step;
    if (sum >= DayTicks) sum -= DayTicks;
    return sum;
  endfunction

  function automatic int unsigned sub_wrapped(int unsigned count, int unsigned step);
    if (count < step) return DayTicks - (step - count);
    return count - step;
  endfunction

  function automatic tod_display_t display_of(int unsigned count, logic led, logic setting);
    tod_display_t d;
    int unsigned  secs_total;
    int unsigned  mins_total;
    int unsigned  hrs;
    int unsigned  mins;
    secs_total     = count / stc_pkg::TicksPerSecond;
    mins_total     = secs_total / 60;
    mins           = mins_total % 60;
    hrs            = mins_total / 60;
    d.hours        = hrs[4:0];
    d.minutes      = mins[5:0];
    d.seconds      = 6'(secs_total % 60);
    d.hour_tens    = 2'(hrs / 10);
    d.hour_units   = 4'(hrs % 10);
    d.minute_tens  = 3'(mins / 10);
    d.minute_units = 4'(mins % 10);
    d.led          = led;
    d.setting      = setting;
    return d;
  endfunction

  task automatic advance_time_of_day(input logic [1:0] op_bits, input logic [3:0] buttons);
    case (stc_pkg::op_e'(op_bits))
      stc_pkg::OpTick: begin
        if (!setting_now) begin
          led_now       = ~led_now;
          day_ticks_now = add_wrapped(day_ticks_now, 1);
        end
      end
      stc_pkg::OpToggle: setting_now = ~setting_now;
      stc_pkg::OpPoll: begin
        if (setting_now) begin
          if (buttons[0]) day_ticks_now = add_wrapped(day_ticks_now, HourTicks);
          if (buttons[1]) day_ticks_now = sub_wrapped(day_ticks_now, HourTicks);
          if (buttons[2]) day_ticks_now = add_wrapped(day_ticks_now, MinuteTicks);
          if (buttons[3]) day_ticks_now = sub_wrapped(day_ticks_now, MinuteTicks);
        end
      end
      default: ;  // unused code: time only reported
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] result %0d: %s got %0d expected %0d", $time, result_index, what, got,
             want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tod_display_t want;
    if (!rst_ni) begin
      day_ticks_now = 0;
      setting_now   = 1'b0;
      led_now       = 1'b0;
      expected_displays.delete();
      pending_o    <= 0;
    end else begin
      // Results leave before the transaction taken at the same edge can produce one.
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_displays.size() == 0) begin
          report_mismatch("unexpected result, tdata", int'(m_axis_tdata), 0);
        end else begin
          want = expected_displays.pop_front();
          check_field("hours_now",    m_axis_tdata[4:0],   want.hours);
          check_field("minutes_now",  m_axis_tdata[10:5],  want.minutes);
          check_field("seconds_now",  m_axis_tdata[16:11], want.seconds);
          check_field("hour_tens",    m_axis_tdata[18:17], want.hour_tens);
          check_field("hour_units",   m_axis_tdata[22:19], want.hour_units);
          check_field("minute_tens",  m_axis_tdata[25:23], want.minute_tens);
          check_field("minute_units", m_axis_tdata[29:26], want.minute_units);
          check_field("second_led",   m_axis_tdata[30],    want.led);
          check_field("setting_mode", m_axis_tdata[31],    want.setting);
        end
        result_index++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_time_of_day(s_axis_tuser, s_axis_tdata[3:0]);
        expected_displays.push_back(display_of(day_ticks_now, led_now, setting_now));
      end
      pending_o <= expected_displays.size();
    end
    fail_count_o <= mismatches;
  end

endmodule

>>> tb/sv/tb_settable_time_of_day_counter.sv
`timescale 1ns / 1ps

module tb_settable_time_of_day_counter;

  localparam logic [1:0] OpUnused   = 2'd3;   // decoded by nobody, must be ignored
  localparam int         CycleLimit = 400000;
  localparam int         ItemTarget = 700;

  // button bit positions in tdata
  localparam logic [3:0] BtnNone   = 4'b0000;
  localparam logic [3:0] BtnHourUp = 4'b0001;
  localparam logic [3:0] BtnHourDn = 4'b0010;
  localparam logic [3:0] BtnMinUp  = 4'b0100;
  localparam logic [3:0] BtnMinDn  = 4'b1000;
  localparam logic [3:0] BtnAll    = 4'b1111;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [3:0] buttons, [7:4] zero
  logic [1:0]  s_axis_tuser  = 2'd0;   // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  int   fail_count;
  int   pending_results;
  int   cycle_count = 0;
  int   burst_left  = 0;
  int   items_sent  = 0;
  logic clock_set   = 1'b0;  // mirror of set mode, only used to shape sequences

  // receiver stall pattern state
  int         ready_style = 0;
  int         ready_left  = 0;
  logic [2:0] ready_phase = 3'd0;
  logic [7:0] ready_mask  = 8'b1100_1010;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  settable_time_of_day_counter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  tod_display_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  // Watchdog: a stuck handshake or a lost result ends here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("settable_time_of_day_counter verification failed");
      $finish;
    end
  end

  // Receiver: picks a new stall style at random whenever its current run ends.
  // 0 always ready, 1 coin flip, 2 mostly stalled, 3 fixed rotating mask.
  always @(posedge clk_i) begin
    if (ready_left == 0) begin
      ready_style = $urandom_range(0, 3);
      ready_left  = $urandom_range(16, 96);
      ready_mask  = 8'($urandom_range(1, 255));
    end else begin
      ready_left--;
    end
    case (ready_style)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= ready_mask[ready_phase];
    endcase
    ready_phase = ready_phase + 3'd1;
  end

  // One transaction on the input side. Bursts of random length, random gaps between.
  task automatic send_event(input logic [1:0] op_bits, input logic [3:0] buttons);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op_bits;
    s_axis_tdata  <= {4'b0000, buttons};
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    items_sent++;
    if (op_bits == stc_pkg::OpToggle) clock_set = ~clock_set;
  endtask

  // Bring the block to a known mode with one toggle if needed.
  task automatic enter_mode(input logic want_set);
    if (clock_set != want_set) send_event(stc_pkg::OpToggle, 4'($urandom_range(0, 15)));
  endtask

  initial begin
    int kind;
    int run_len;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: ignored events, exact day wraps on steps, button combinations.
    send_event(OpUnused, BtnNone);                   // unused code at reset time
    send_event(stc_pkg::OpPoll, BtnAll);             // poll while running: no effect
    send_event(stc_pkg::OpToggle, BtnNone);          // into set mode
    send_event(stc_pkg::OpTick, BtnAll);             // tick while stopped: no effect
    send_event(stc_pkg::OpPoll, BtnNone);            // nothing held
    send_event(stc_pkg::OpPoll, BtnMinDn);           // 00:00 -> 23:59, minute below zero
    send_event(stc_pkg::OpPoll, BtnMinUp);           // lands exactly on a full day -> 00:00
    send_event(stc_pkg::OpPoll, BtnHourDn);          // 00:00 -> 23:00
    send_event(stc_pkg::OpPoll, BtnHourUp);          // full day again -> 00:00
    send_event(stc_pkg::OpPoll, BtnHourUp | BtnHourDn);
    send_event(stc_pkg::OpPoll, BtnMinUp | BtnMinDn);
    send_event(stc_pkg::OpPoll, BtnAll);
    send_event(stc_pkg::OpPoll, BtnHourDn | BtnMinDn);
    send_event(stc_pkg::OpPoll, BtnHourUp | BtnMinUp);
    send_event(OpUnused, BtnAll);                    // unused code in set mode
    send_event(stc_pkg::OpPoll, BtnMinDn);           // park at 23:59:00
    send_event(stc_pkg::OpToggle, BtnAll);           // run again
    // Midnight rollover on ticks: two ticks a second, 60 seconds to go.
    repeat (2 * 60 + 1) send_event(stc_pkg::OpTick, 4'($urandom_range(0, 15)));

    // Random: mostly well-formed tick runs and set sessions, some noise.
    while (items_sent < ItemTarget) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        enter_mode(1'b0);
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 160) : $urandom_range(1, 40);
        repeat (run_len) send_event(stc_pkg::OpTick, 4'($urandom_range(0, 15)));
      end else if (kind < 8) begin
        enter_mode(1'b1);
        run_len = $urandom_range(1, 10);
        repeat (run_len) send_event(stc_pkg::OpPoll, 4'($urandom_range(0, 15)));
      end else begin
        repeat ($urandom_range(1, 6))
          send_event(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain: the checker's count is registered, so it lags the edge.
    do @(posedge clk_i); while (pending_results != 0);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("settable_time_of_day_counter verification clean");
    end else begin
      $display("settable_time_of_day_counter verification failed");
    end
    $finish;
  end

endmodule
